>>> src/quintic_trajectory_interpolator_defines.svh
// Assertion helpers for the block's top-level RTL file.
`ifndef QUINTIC_TRAJECTORY_INTERPOLATOR_DEFINES_SVH
`define QUINTIC_TRAJECTORY_INTERPOLATOR_DEFINES_SVH

// Condition that must hold at every clock edge outside reset.
`define QTI_ASSERT_ALWAYS(name, expr, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (expr)) else $error(msg);

// Condition that must hold in the cycle after a trigger.
`define QTI_ASSERT_NEXT(name, trig, expr, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (trig) |=> (expr)) else $error(msg);

`endif

>>> src/qti_pkg.sv
package qti_pkg;

  // Request kinds.
  localparam logic REQ_SETUP = 1'b0;
  localparam logic REQ_EVAL  = 1'b1;

  // Result status codes.
  localparam logic [1:0] STAT_NOT_ARMED = 2'd0;
  localparam logic [1:0] STAT_MOVING    = 2'd1;
  localparam logic [1:0] STAT_FINISHED  = 2'd2;
  localparam logic [1:0] STAT_SETUP     = 2'd3;

  // Width of the serial divider's quotient, remainder and divisor.
  localparam int DIV_W = 48;

  typedef struct packed {
    logic               req_type;
    logic [2:0]         joint;
    logic signed [31:0] start_pos;
    logic signed [31:0] target_pos;
    logic [31:0]        start_tick;
    logic [23:0]        move_ticks;
    logic [31:0]        now_tick;
  } req_t;

  typedef struct packed {
    logic signed [31:0] position;
    logic signed [47:0] velocity;
    logic signed [47:0] acceleration;
    logic [1:0]         status;
  } rsp_t;

  // One joint's stored move.
  typedef struct packed {
    logic signed [31:0] origin_pos;
    logic signed [31:0] goal_pos;
    logic [31:0]        begin_tick;
    logic [23:0]        span_ticks;
  } entry_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_LOOKUP,
    S_TAU,
    S_MUL,
    S_VDIV,
    S_ADIV,
    S_DONE
  } state_t;

  // Steps of the shared multiplier sequence.
  typedef enum logic [3:0] {
    M_TT,
    M_UU,
    M_TU,
    M_T3,
    M_V0,
    M_A0,
    M_SF,
    M_SQ,
    M_POS,
    M_VEL,
    M_ACC,
    M_LAST
  } mstep_t;

  // Request to the serial divider.
  typedef struct packed {
    logic             start;
    logic [5:0]       steps;
    logic [DIV_W-1:0] rem_init;
    logic [DIV_W-1:0] num;
    logic [DIV_W-1:0] divisor;
  } div_req_t;

endpackage

>>> src/qti_ram.sv
module qti_ram #(
  parameter int WIDTH = 120,
  parameter int DEPTH = 8,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // One write port and one registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> src/qti_div.sv
module qti_div import qti_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  div_req_t         req,
  output logic             done,
  output logic [DIV_W-1:0] quot
);

  logic [DIV_W-1:0] rem;
  logic [DIV_W-1:0] num;
  logic [DIV_W-1:0] divisor;
  logic [5:0]       cnt;
  logic             run;
  logic [DIV_W:0]   trial;
  logic [DIV_W:0]   diff;
  logic             ge;

  // One restoring step: bring down the next dividend bit and try the subtract.
  always_comb begin
    trial = {rem, num[DIV_W-1]};
    diff  = trial - {1'b0, divisor};
    ge    = (trial >= {1'b0, divisor});
  end

  // Step counter and completion pulse.
  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      cnt  <= '0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        run <= 1'b1;
        cnt <= req.steps;
      end else if (run) begin
        cnt <= cnt - 6'd1;
        if (cnt == 6'd1) begin
          run  <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // Remainder, dividend and quotient shift registers.
  always_ff @(posedge clk) begin
    if (req.start) begin
      rem     <= req.rem_init;
      num     <= req.num;
      divisor <= req.divisor;
      quot    <= '0;
    end else if (run) begin
      rem  <= ge ? diff[DIV_W-1:0] : trial[DIV_W-1:0];
      num  <= {num[DIV_W-2:0], 1'b0};
      quot <= {quot[DIV_W-2:0], ge};
    end
  end

endmodule

>>> src/quintic_trajectory_interpolator.sv
// Channel   Signals                    Transfer
// request   start, busy, req (req_t)   start high while busy low
// result    rsp_strobe, rsp (rsp_t)    every cycle with rsp_strobe high
//
// A setup or an out-of-range joint shows its result in the cycle after the transfer.
// Finished and not-armed evaluates pass through S_LOOKUP and show it once the table is read.
// A moving evaluate shows it after a TAU_FRAC_BITS-step divide for tau,
// then 12 multiplier steps, then two 48-step divides.
// Busy stays high through the result cycle; the receiver cannot stall results.
// Reset clears the armed bits and the controller; table entries hold garbage.
`include "quintic_trajectory_interpolator_defines.svh"

module quintic_trajectory_interpolator import qti_pkg::*; #(
  parameter int JOINTS        = 8,
  parameter int TAU_FRAC_BITS = 24
) (
  input  logic clk,
  input  logic rst,
  input  logic start,
  input  req_t req,
  output logic busy,
  output logic rsp_strobe,
  output rsp_t rsp
);

  localparam int F     = TAU_FRAC_BITS;
  localparam int AW    = (JOINTS > 1) ? $clog2(JOINTS) : 1;
  localparam int EW    = $bits(entry_t);
  localparam int OPW   = (F + 7 > 33) ? F + 7 : 33;
  localparam int PW    = 2 * OPW;
  localparam int NW    = PW + 12;
  localparam int IW    = F + 5;
  localparam int VSH_L = (F < 16) ? 16 - F : 0;
  localparam int VSH_R = (F > 16) ? F - 16 : 0;
  localparam int ASH_L = (F < 24) ? 24 - F : 0;
  localparam int ASH_R = (F > 24) ? F - 24 : 0;
  localparam logic [F:0] ONE = (F + 1)'(1) << F;

  state_t          state;
  state_t          state_next;
  mstep_t          step;
  logic [JOINTS-1:0] armed;
  logic [AW-1:0]   jaddr;
  logic [31:0]     now_q;
  entry_t          ent;
  entry_t          rent;
  logic [EW-1:0]   rdata;
  logic            ram_we;
  logic            accept;
  logic            in_range;
  logic [31:0]     elapsed;
  logic            fin;
  logic            hit_armed;
  logic signed [32:0] d33;
  logic            dneg;
  logic [32:0]     dmag;
  div_req_t        div_req;
  logic            div_done;
  logic [DIV_W-1:0] quot;

  // Displacement magnitude and sign kept from the table read.
  logic [32:0]     dmag_q;
  logic            dneg_q;

  logic [F-1:0]    t;
  logic [F:0]      u;
  logic [F-1:0]    t2;
  logic [F:0]      uu;
  logic [F-1:0]    tu;
  logic [F-1:0]    t3;
  logic [F+5:0]    vf;
  logic [F+6:0]    af;
  logic [F:0]      sf;
  logic [47:0]     span2;
  logic [32:0]     pmag;
  logic [PW-1:0]   pv;
  logic [PW-1:0]   pa;
  logic [OPW-1:0]  ma;
  logic [OPW-1:0]  mb;
  logic [PW-1:0]   mprod;
  logic [PW-1:0]   mq;
  logic [IW-1:0]   hpart;
  logic [IW-1:0]   lpart;
  logic [IW-1:0]   inner;
  logic [F:0]      w;
  logic            aneg;
  logic [NW-1:0]   nv;
  logic [NW-1:0]   na;
  logic            vsat;
  logic            asat;
  logic signed [34:0] posx;
  logic [31:0]     pos_sat;

  // Magnitude saturation to the signed 48-bit range, then the sign.
  function automatic logic [47:0] sat48(input logic [47:0] q, input logic sat,
                                        input logic neg);
    logic [47:0] lim;
    logic [47:0] m;
    lim = neg ? 48'h8000_0000_0000 : 48'h7FFF_FFFF_FFFF;
    m   = (sat || (q > lim)) ? lim : q;
    return neg ? (48'd0 - m) : m;
  endfunction

  assign accept   = start && !busy;
  assign in_range = ({29'd0, req.joint} < 32'(JOINTS));
  assign ram_we   = accept && in_range && (req.req_type == REQ_SETUP);

  // Move table.
  qti_ram #(
    .WIDTH(EW),
    .DEPTH(JOINTS),
    .AW   (AW)
  ) u_table (
    .clk  (clk),
    .we   (ram_we),
    .waddr(AW'(req.joint)),
    .wdata({req.start_pos, req.target_pos, req.start_tick, req.move_ticks}),
    .raddr(AW'(req.joint)),
    .rdata(rdata)
  );

  // Shared serial divider.
  qti_div u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .done(div_done),
    .quot(quot)
  );

  // Elapsed ticks and the finish test on the entry just read.
  always_comb begin
    rent      = entry_t'(rdata);
    elapsed   = (now_q >= rent.begin_tick) ? (now_q - rent.begin_tick) : 32'd0;
    fin       = (elapsed >= {8'd0, rent.span_ticks});
    hit_armed = armed[jaddr];
    d33       = 33'(rent.goal_pos) - 33'(rent.origin_pos);
    dneg      = d33[32];
    dmag      = dneg ? (33'd0 - d33) : d33;
  end

  // Operand selection for the shared multiplier.
  always_comb begin
    ma = '0;
    mb = '0;
    case (step)
      M_TT:  begin ma = OPW'(t);         mb = OPW'(t);     end
      M_UU:  begin ma = OPW'(u);         mb = OPW'(u);     end
      M_TU:  begin ma = OPW'(t);         mb = OPW'(u);     end
      M_T3:  begin ma = OPW'(t2);        mb = OPW'(t);     end
      M_V0:  begin ma = OPW'(t2);        mb = OPW'(uu);    end
      M_A0:  begin ma = OPW'(tu);        mb = OPW'(w);     end
      M_SF:  begin ma = OPW'(t3);        mb = OPW'(inner); end
      M_SQ:  begin ma = OPW'(ent.span_ticks); mb = OPW'(ent.span_ticks); end
      M_POS: begin ma = OPW'(dmag_q);    mb = OPW'(sf);    end
      M_VEL: begin ma = OPW'(dmag_q);    mb = OPW'(vf);    end
      M_ACC: begin ma = OPW'(dmag_q);    mb = OPW'(af);    end
      default: begin ma = '0;            mb = '0;          end
    endcase
  end

  // Polynomial terms and rate numerators.
  always_comb begin
    mq    = mprod >> F;
    hpart = (IW'(t2) << 2) + (IW'(t2) << 1) + (IW'(10) << F);
    lpart = (IW'(t) << 4) - IW'(t);
    inner = (hpart > lpart) ? (hpart - lpart) : '0;
    w     = (u >= {1'b0, t}) ? (u - {1'b0, t}) : ({1'b0, t} - u);
    aneg  = dneg_q ^ ({1'b0, t} > u);
    nv    = (NW'(pv) << VSH_L) >> VSH_R;
    na    = (NW'(pa) << ASH_L) >> ASH_R;
    posx  = 35'(ent.origin_pos) +
            (dneg_q ? -$signed({2'b00, pmag}) : $signed({2'b00, pmag}));
    if (posx[34:31] != {4{posx[31]}}) begin
      pos_sat = posx[34] ? 32'h8000_0000 : 32'h7FFF_FFFF;
    end else begin
      pos_sat = posx[31:0];
    end
  end

  // Next state.
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (accept) begin
          if (!in_range || (req.req_type == REQ_SETUP)) begin
            state_next = S_DONE;
          end else begin
            state_next = S_LOOKUP;
          end
        end
      end
      S_LOOKUP: begin
        if (fin || !hit_armed) begin
          state_next = S_DONE;
        end else begin
          state_next = S_TAU;
        end
      end
      S_TAU: begin
        if (div_done) begin
          state_next = S_MUL;
        end
      end
      S_MUL: begin
        if (step == M_LAST) begin
          state_next = S_VDIV;
        end
      end
      S_VDIV: begin
        if (div_done) begin
          state_next = S_ADIV;
        end
      end
      S_ADIV: begin
        if (div_done) begin
          state_next = S_DONE;
        end
      end
      S_DONE: state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  // Controller outputs and divider requests.
  always_comb begin
    busy       = (state != S_IDLE);
    rsp_strobe = (state == S_DONE);
    div_req    = '0;
    unique case (state)
      S_LOOKUP: begin
        if (!fin && hit_armed) begin
          div_req.start    = 1'b1;
          div_req.steps    = 6'(F);
          div_req.rem_init = DIV_W'(elapsed);
          div_req.num      = '0;
          div_req.divisor  = DIV_W'(rent.span_ticks);
        end
      end
      S_MUL: begin
        if (step == M_LAST) begin
          div_req.start    = 1'b1;
          div_req.steps    = 6'(DIV_W);
          div_req.rem_init = DIV_W'(nv >> DIV_W);
          div_req.num      = nv[DIV_W-1:0];
          div_req.divisor  = DIV_W'(ent.span_ticks);
        end
      end
      S_VDIV: begin
        if (div_done) begin
          div_req.start    = 1'b1;
          div_req.steps    = 6'(DIV_W);
          div_req.rem_init = DIV_W'(na >> DIV_W);
          div_req.num      = na[DIV_W-1:0];
          div_req.divisor  = span2;
        end
      end
      default: div_req = '0;
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      step  <= M_TT;
      armed <= '0;
    end else begin
      state <= state_next;
      if (state == S_MUL) begin
        step <= (step == M_LAST) ? M_TT : mstep_t'(step + 4'd1);
      end else begin
        step <= M_TT;
      end
      if (ram_we) begin
        armed[AW'(req.joint)] <= 1'b1;
      end else if ((state == S_LOOKUP) && fin) begin
        armed[jaddr] <= 1'b0;
      end
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    mprod <= PW'(ma) * PW'(mb);

    if (accept) begin
      jaddr <= AW'(req.joint);
      now_q <= req.now_tick;
      if (!in_range) begin
        rsp.position     <= '0;
        rsp.velocity     <= '0;
        rsp.acceleration <= '0;
        rsp.status       <= STAT_NOT_ARMED;
      end else if (req.req_type == REQ_SETUP) begin
        rsp.position     <= req.start_pos;
        rsp.velocity     <= '0;
        rsp.acceleration <= '0;
        rsp.status       <= STAT_SETUP;
      end
    end

    if (state == S_LOOKUP) begin
      ent    <= rent;
      dmag_q <= dmag;
      dneg_q <= dneg;
      if (fin) begin
        rsp.position     <= rent.goal_pos;
        rsp.velocity     <= '0;
        rsp.acceleration <= '0;
        rsp.status       <= STAT_FINISHED;
      end else if (!hit_armed) begin
        rsp.position     <= '0;
        rsp.velocity     <= '0;
        rsp.acceleration <= '0;
        rsp.status       <= STAT_NOT_ARMED;
      end
    end

    if ((state == S_TAU) && div_done) begin
      t <= quot[F-1:0];
      u <= ONE - {1'b0, quot[F-1:0]};
    end

    // Each step keeps the product issued in the step before.
    if (state == S_MUL) begin
      case (step)
        M_UU:  t2    <= F'(mq);
        M_TU:  uu    <= (F + 1)'(mq);
        M_T3:  tu    <= F'(mq);
        M_V0:  t3    <= F'(mq);
        M_A0:  vf    <= (F + 6)'((mq << 5) - (mq << 1));
        M_SF:  af    <= (F + 7)'((mq << 6) - (mq << 2));
        M_SQ:  sf    <= (mq > PW'(ONE)) ? ONE : (F + 1)'(mq);
        M_POS: span2 <= 48'(mprod);
        M_VEL: pmag  <= 33'(mq);
        M_ACC: pv    <= mprod;
        M_LAST: begin
          pa           <= mprod;
          rsp.position <= pos_sat;
          vsat         <= ((nv >> DIV_W) >= NW'(ent.span_ticks));
        end
        default: ;
      endcase
    end

    if ((state == S_VDIV) && div_done) begin
      rsp.velocity <= sat48(quot, vsat, dneg_q);
      asat         <= ((na >> DIV_W) >= NW'(span2));
    end

    if ((state == S_ADIV) && div_done) begin
      rsp.acceleration <= sat48(quot, asat, aneg);
      rsp.status       <= STAT_MOVING;
    end
  end

  `QTI_ASSERT_ALWAYS(a_strobe_in_busy, !rsp_strobe || busy, "result shown while idle")
  `QTI_ASSERT_NEXT(a_accept_busy, start && !busy, busy, "busy not raised after transfer")
  `QTI_ASSERT_NEXT(a_strobe_single, rsp_strobe, !rsp_strobe, "result shown twice")
  `QTI_ASSERT_NEXT(a_setup_fast, start && !busy && (req.req_type == REQ_SETUP), rsp_strobe,
                   "setup result not given in the next cycle")

endmodule

>>> tb/tb_quintic_trajectory_interpolator.sv
`timescale 1ns / 1ps

module tb_quintic_trajectory_interpolator import qti_pkg::*; ();

  localparam int TAU_F = 24;
  localparam int NUM_JOINTS = 8;
  localparam longint CYCLE_LIMIT = 1000000;
  localparam int SETTLE_CYCLES = 200;

  typedef logic [127:0] u128;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  req_t req = '0;
  logic busy;
  logic rsp_strobe;
  rsp_t rsp;

  // Shadow copy of the per-joint move table.
  bit     joint_armed [NUM_JOINTS];
  bit     joint_loaded [NUM_JOINTS];
  entry_t move_table [NUM_JOINTS];

  rsp_t   pending_rsp [$];
  int     error_count = 0;
  int     rsp_count = 0;
  int     setup_count = 0;
  int     moving_count = 0;
  int     finished_count = 0;
  int     idle_count = 0;
  longint cycle_count = 0;

  quintic_trajectory_interpolator dut (
    .clk(clk),
    .rst(rst),
    .start(start),
    .req(req),
    .busy(busy),
    .rsp_strobe(rsp_strobe),
    .rsp(rsp)
  );

  // Free-running clock with a 4 ns period.
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Run limit.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("FAIL");
      $finish;
    end
  end

  function automatic logic [63:0] frac_mul(logic [63:0] a, logic [63:0] b);
    u128 p;
    p = u128'(a) * u128'(b);
    return 64'(p >> TAU_F);
  endfunction

  // Truncated magnitude to a saturated signed 48-bit field.
  function automatic logic [47:0] sat48(u128 mag, bit neg);
    u128 lim;
    u128 m;
    lim = neg ? u128'(48'h800000000000) : u128'(48'h7FFFFFFFFFFF);
    m = (mag > lim) ? lim : mag;
    return neg ? 48'(-m) : 48'(m);
  endfunction

  // Works out the response of one request and updates the shadow table.
  function automatic rsp_t quintic_response(req_t r);
    rsp_t o;
    entry_t e;
    logic [63:0] one, elapsed, span, t, u, t2, t3, hpart, lpart, inner;
    logic [63:0] s_f, v_f, a_f, tu, w, dmag, pmag;
    longint d, pos;
    bit dneg;
    o = '0;
    one = 64'd1 << TAU_F;
    if (r.req_type == REQ_SETUP) begin
      e.origin_pos = r.start_pos;
      e.goal_pos   = r.target_pos;
      e.begin_tick = r.start_tick;
      e.span_ticks = r.move_ticks;
      move_table[r.joint] = e;
      joint_armed[r.joint] = 1'b1;
      o.position = r.start_pos;
      o.status = STAT_SETUP;
      return o;
    end
    e = move_table[r.joint];
    elapsed = (r.now_tick >= e.begin_tick) ? 64'(r.now_tick - e.begin_tick) : 64'd0;
    span = 64'(e.span_ticks);
    if (elapsed >= span) begin
      joint_armed[r.joint] = 1'b0;
      o.position = e.goal_pos;
      o.status = STAT_FINISHED;
      return o;
    end
    if (!joint_armed[r.joint]) return o;

    // Normalized time and the shape polynomials.
    t = (elapsed << TAU_F) / span;
    u = one - t;
    t2 = frac_mul(t, t);
    t3 = frac_mul(t2, t);
    hpart = 6 * t2 + 10 * one;
    lpart = 15 * t;
    inner = (hpart > lpart) ? hpart - lpart : 64'd0;
    s_f = frac_mul(t3, inner);
    if (s_f > one) s_f = one;
    v_f = 30 * frac_mul(t2, frac_mul(u, u));
    tu = frac_mul(t, u);
    w = (u >= t) ? u - t : t - u;
    a_f = 60 * frac_mul(tu, w);

    // Scale by the move distance.
    d = longint'(e.goal_pos) - longint'(e.origin_pos);
    dneg = d < 0;
    dmag = dneg ? 64'(-d) : 64'(d);
    pmag = 64'((u128'(dmag) * u128'(s_f)) >> TAU_F);
    pos = longint'(e.origin_pos) + (dneg ? -longint'(pmag) : longint'(pmag));
    if (pos > 64'sd2147483647) pos = 64'sd2147483647;
    if (pos < -64'sd2147483648) pos = -64'sd2147483648;
    o.position = 32'(pos);
    o.velocity = sat48(((u128'(dmag) * u128'(v_f)) >> (TAU_F - 16)) / u128'(span), dneg);
    o.acceleration = sat48(((u128'(dmag) * u128'(a_f)) >> (TAU_F - 24)) /
                           (u128'(span) * u128'(span)), dneg != (t > u));
    o.status = STAT_MOVING;
    return o;
  endfunction

  task automatic report_mismatch(string field, logic [63:0] got, logic [63:0] want);
    error_count++;
    $display("mismatch on %s at cycle %0d: got %h, expected %h", field, cycle_count, got,
             want);
  endtask

  // Result checker.
  always @(posedge clk) begin
    rsp_t want;
    if (!rst && rsp_strobe) begin
      rsp_count++;
      if (pending_rsp.size() == 0) begin
        report_mismatch("unexpected result", 64'(rsp.status), 64'd0);
      end else begin
        want = pending_rsp.pop_front();
        if (rsp.position !== want.position)
          report_mismatch("position", 64'(rsp.position), 64'(want.position));
        if (rsp.velocity !== want.velocity)
          report_mismatch("velocity", 64'(rsp.velocity), 64'(want.velocity));
        if (rsp.acceleration !== want.acceleration)
          report_mismatch("acceleration", 64'(rsp.acceleration), 64'(want.acceleration));
        if (rsp.status !== want.status)
          report_mismatch("status", 64'(rsp.status), 64'(want.status));
      end
    end
  end

  // Drives one request and waits for its transfer; start stays high afterward.
  task automatic send_request(req_t r);
    rsp_t want;
    start <= 1'b1;
    req <= r;
    @(posedge clk);
    while (busy) @(posedge clk);
    if (r.req_type == REQ_SETUP) joint_loaded[r.joint] = 1'b1;
    want = quintic_response(r);
    case (want.status)
      STAT_SETUP:    setup_count++;
      STAT_MOVING:   moving_count++;
      STAT_FINISHED: finished_count++;
      default:       idle_count++;
    endcase
    pending_rsp.push_back(want);
  endtask

  // Mostly no gap, sometimes short, now and then long.
  task automatic sender_gap();
    int pick;
    int n;
    pick = $urandom_range(0, 99);
    n = (pick < 60) ? 0 : (pick < 90) ? $urandom_range(1, 3) : $urandom_range(10, 60);
    if (n > 0) begin
      start <= 1'b0;
      repeat (n) @(posedge clk);
    end
  endtask

  task automatic wait_drained();
    while (pending_rsp.size() != 0) @(posedge clk);
  endtask

  function automatic req_t setup_req(logic [2:0] j, logic [31:0] p0, logic [31:0] p1,
                                     logic [31:0] t0, logic [23:0] n);
    req_t r;
    r = '0;
    r.req_type = REQ_SETUP;
    r.joint = j;
    r.start_pos = p0;
    r.target_pos = p1;
    r.start_tick = t0;
    r.move_ticks = n;
    return r;
  endfunction

  function automatic req_t eval_req(logic [2:0] j, logic [31:0] now);
    req_t r;
    r = '0;
    r.req_type = REQ_EVAL;
    r.joint = j;
    r.now_tick = now;
    return r;
  endfunction

  // Field extremes, zero and full durations, ticks before start, finish and disarm.
  task automatic test_directed();
    send_request(setup_req(3'd0, 32'h80000000, 32'h7FFFFFFF, 32'd100, 24'd1000));
    send_request(eval_req(3'd0, 32'd50));
    send_request(eval_req(3'd0, 32'd600));
    send_request(eval_req(3'd0, 32'd1099));
    send_request(eval_req(3'd0, 32'd1100));
    send_request(eval_req(3'd0, 32'd50));
    send_request(setup_req(3'd7, 32'h7FFFFFFF, 32'h80000000, 32'hFFFFFFFF, 24'hFFFFFF));
    send_request(eval_req(3'd7, 32'hFFFFFFFF));
    send_request(eval_req(3'd7, 32'd0));
    sender_gap();
    send_request(setup_req(3'd7, 32'h7FFFFFFF, 32'h80000000, 32'd0, 24'hFFFFFF));
    send_request(eval_req(3'd7, 32'h00400000));
    send_request(eval_req(3'd7, 32'h00C00000));
    send_request(eval_req(3'd7, 32'hFFFFFFFF));
    send_request(setup_req(3'd3, 32'd5, 32'd9, 32'd10, 24'd0));
    send_request(eval_req(3'd3, 32'd0));
    send_request(setup_req(3'd4, 32'h00010000, 32'h00010000, 32'd0, 24'd1));
    send_request(eval_req(3'd4, 32'd0));
    send_request(eval_req(3'd4, 32'd1));
    send_request(setup_req(3'd5, 32'h0, 32'h00100000, 32'd0, 24'd2));
    send_request(eval_req(3'd5, 32'd1));
    send_request(setup_req(3'd6, 32'h00100000, 32'h0, 32'd0, 24'd3));
    send_request(eval_req(3'd6, 32'd2));
    start <= 1'b0;
  endtask

  // The sender holds off until the table has answered everything in flight.
  task automatic test_drain_pause();
    wait_drained();
    send_request(eval_req(3'd0, 32'd700));
    send_request(eval_req(3'd5, 32'd0));
    start <= 1'b0;
    wait_drained();
  endtask

  // Mostly coherent setup and evaluate sequences, plus unrelated ticks.
  task automatic test_random(int count);
    logic [2:0] j;
    logic [23:0] n;
    logic [31:0] p0, p1, t0, now;
    int pick;
    for (int i = 0; i < count; i++) begin
      j = 3'($urandom_range(0, NUM_JOINTS - 1));
      pick = $urandom_range(0, 99);
      if (!joint_loaded[j] || pick < 25) begin
        pick = $urandom_range(0, 99);
        n = (pick < 5) ? 24'd0 : (pick < 10) ? 24'($urandom) :
            (pick < 15) ? 24'hFFFFFF : 24'($urandom_range(1, 2000));
        p0 = $urandom;
        p1 = ($urandom_range(0, 3) == 0) ? $urandom : p0 + 32'($urandom_range(0, 1 << 22))
             - 32'(1 << 21);
        t0 = $urandom;
        send_request(setup_req(j, p0, p1, t0, n));
      end else begin
        pick = $urandom_range(0, 99);
        t0 = move_table[j].begin_tick;
        n = move_table[j].span_ticks;
        if (pick < 75)
          now = t0 + 32'($urandom_range(0, int'(n) + int'(n) / 8 + 1));
        else if (pick < 85)
          now = t0 - 32'($urandom_range(1, 100));
        else
          now = $urandom;
        send_request(eval_req(j, now));
      end
      sender_gap();
    end
    start <= 1'b0;
  endtask

  initial begin
    for (int k = 0; k < NUM_JOINTS; k++) begin
      joint_armed[k] = 1'b0;
      joint_loaded[k] = 1'b0;
      move_table[k] = '0;
    end
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_directed();
    test_drain_pause();
    test_random(600);

    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
    $display("covered %0d results: %0d setups, %0d moving, %0d finished, %0d idle joints",
             rsp_count, setup_count, moving_count, finished_count, idle_count);
    $display("mismatches found: %0d", error_count);
    if (error_count == 0 && pending_rsp.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
